@@ rtl/core/rbuv_pkg.sv @@
// ----------------------------------------------------------------------------
// rbuv_pkg: shared widths and types for the rotation-between-vectors block
// Fixed-point widths of each pipeline quantity and the structs that travel
// between the front stages, the divider and the output buffer.
// ----------------------------------------------------------------------------
package rbuv_pkg;

  // Field widths
  localparam int IN_W   = 16;            // input component, signed Q2.14
  localparam int OUT_W  = 16;            // matrix entry, signed Q2.14
  localparam int CFG_W  = 16;            // min_denominator register
  localparam int FRAC_W = 14;            // fraction bits of Q2.14

  // Internal widths
  localparam int PROD_W = 32;            // a_i * b_j, exact Q.28
  localparam int DIFF_W = 33;            // cross-product difference / dot partial
  localparam int C_W    = 19;            // rounded cross component, |c| <= 2^17
  localparam int DEN_W  = 34;            // 1 + a.b in Q.28, signed
  localparam int DIV_W  = 32;            // divisor once known positive
  localparam int SQ_W   = 38;            // c_i * c_j product
  localparam int MAG_W  = 36;            // |[c]x^2 entry|, up to 2^35
  localparam int NUM_W  = MAG_W + FRAC_W + 1;  // |h| * 2^14 + den / 2
  localparam int QUO_W  = 20;            // quotient bits kept, larger values clamp
  localparam int ENT_W  = 23;            // identity + hat + quotient before saturation

  // Structure
  localparam int LANES   = 6;            // distinct entries of [c]x^2
  localparam int NENT    = 9;            // matrix entries
  localparam int DIV_ST  = QUO_W + 1;    // range check stage plus one stage per bit
  localparam int PRE_ST  = 6;            // stages ahead of the divider
  localparam int PIPE_ST = PRE_ST + DIV_ST;

  // Constants
  localparam int ONE_Q14 = 1 << FRAC_W;
  localparam int ONE_Q28 = 1 << (2 * FRAC_W);
  localparam int RND_POS = 1 << (FRAC_W - 1);
  localparam int RND_NEG = (1 << (FRAC_W - 1)) - 1;
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;
  localparam int CFG_RST = 1;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DIV_W-1:0] div_t;
  typedef logic [QUO_W-1:0] quo_t;

  // Sideband that rides alongside the divider
  typedef struct packed {
    logic signed [C_W-1:0] c0;
    logic signed [C_W-1:0] c1;
    logic signed [C_W-1:0] c2;
    logic [LANES-1:0]      neg;
    logic                  degen;
  } side_t;

  // One finished result item
  typedef struct packed {
    logic [NENT-1:0][OUT_W-1:0] ent;
    logic                       degen;
  } res_t;

endpackage

@@ rtl/core/rbuv_div.sv @@
// ----------------------------------------------------------------------------
// rbuv_div: six-lane pipelined restoring divider
// Computes floor(num / den) for six numerators over one shared divisor, one
// quotient bit per stage. A quotient that does not fit QUO_W bits comes out
// as all ones.
// ----------------------------------------------------------------------------
module rbuv_div (
  input  logic            clk,
  input  logic            en,
  input  rbuv_pkg::num_t  num_i [rbuv_pkg::LANES],
  input  rbuv_pkg::div_t  den_i,
  output rbuv_pkg::quo_t  quo_o [rbuv_pkg::LANES]
);

  localparam int QW = rbuv_pkg::QUO_W;
  localparam int NW = rbuv_pkg::NUM_W;
  localparam int DW = rbuv_pkg::DIV_W;
  localparam int DS = rbuv_pkg::DIV_ST;

  // Divisor travels with the lanes
  rbuv_pkg::div_t d_r [DS];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= den_i;
    end
  end

  for (genvar s = 1; s < DS; s++) begin : g_dstage
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s] <= d_r[s-1];
      end
    end
  end

  for (genvar l = 0; l < rbuv_pkg::LANES; l++) begin : g_lane
    rbuv_pkg::div_t rem_r [DS];
    rbuv_pkg::quo_t lo_r  [DS];
    rbuv_pkg::quo_t q_r   [DS];
    logic           ovf_r [DS];

    // Range check: upper numerator bits must stay below the divisor
    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[0] <= DW'(num_i[l][NW-1:QW]) >= den_i;
        rem_r[0] <= DW'(num_i[l][NW-1:QW]);
        lo_r[0]  <= num_i[l][QW-1:0];
        q_r[0]   <= '0;
      end
    end

    // One quotient bit per stage, MSB first
    for (genvar s = 1; s < DS; s++) begin : g_step
      logic [DW:0]    t;
      logic [DW:0]    sub;
      logic           ge;
      rbuv_pkg::div_t rem_nxt;

      assign t       = {rem_r[s-1], lo_r[s-1][QW-1]};
      assign sub     = t - {1'b0, d_r[s-1]};
      assign ge      = t >= {1'b0, d_r[s-1]};
      assign rem_nxt = ge ? sub[DW-1:0] : t[DW-1:0];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          lo_r[s]  <= {lo_r[s-1][QW-2:0], 1'b0};
          q_r[s]   <= {q_r[s-1][QW-2:0], ge};
          ovf_r[s] <= ovf_r[s-1];
        end
      end
    end

    // Clamp: any clamped value saturates the entry the same way
    assign quo_o[l] = ovf_r[DS-1] ? '1 : q_r[DS-1];
  end

endmodule

@@ rtl/core/rotation_between_unit_vectors.sv @@
// ----------------------------------------------------------------------------
// rotation_between_unit_vectors: rotation matrix taking unit vector a onto b
// Builds R = I + [c]x + [c]x^2 / (1 + a.b) with c = a x b, all in Q2.14.
// ----------------------------------------------------------------------------
// Usage: one item (a, b) is taken per clock while in_tready is high, and one
// result item comes out per item, in order. Each item passes six front stages
// (products, differences, rounding, squares, magnitudes, numerators), then
// the divider, which spends one stage on a range check and one stage per
// quotient bit for 20 bits. The output holds a two-entry buffer, so the input
// keeps flowing while a result waits; in_tready falls only when both entries
// are full. When 1 + a.b is at or below min_denominator (Q2.14) the item
// carries out_tuser = 1 and an all-zero matrix. Write cfg_wdata with cfg_we
// only while no items are in flight.
// ----------------------------------------------------------------------------
module rotation_between_unit_vectors (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,      // min_denominator
  // Input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,       // a_x, a_y, a_z, b_x, b_y, b_z
  // Result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,      // r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic         out_tuser       // degenerate
);

  localparam int IN_W   = rbuv_pkg::IN_W;
  localparam int OUT_W  = rbuv_pkg::OUT_W;
  localparam int FRAC_W = rbuv_pkg::FRAC_W;
  localparam int PROD_W = rbuv_pkg::PROD_W;
  localparam int DIFF_W = rbuv_pkg::DIFF_W;
  localparam int RND_W  = rbuv_pkg::DIFF_W + 1;
  localparam int C_W    = rbuv_pkg::C_W;
  localparam int DEN_W  = rbuv_pkg::DEN_W;
  localparam int DIV_W  = rbuv_pkg::DIV_W;
  localparam int SQ_W   = rbuv_pkg::SQ_W;
  localparam int MAG_W  = rbuv_pkg::MAG_W;
  localparam int NUM_W  = rbuv_pkg::NUM_W;
  localparam int ENT_W  = rbuv_pkg::ENT_W;
  localparam int LANES  = rbuv_pkg::LANES;
  localparam int NENT   = rbuv_pkg::NENT;
  localparam int DS     = rbuv_pkg::DIV_ST;
  localparam int NST    = rbuv_pkg::PIPE_ST;

  // Divider lanes, named by the [c]x^2 entry they carry
  localparam int LN_S00 = 0;
  localparam int LN_S01 = 1;
  localparam int LN_S02 = 2;
  localparam int LN_S11 = 3;
  localparam int LN_S12 = 4;
  localparam int LN_S22 = 5;

  localparam logic signed [ENT_W-1:0] ONE_E  = ENT_W'(rbuv_pkg::ONE_Q14);
  localparam logic signed [ENT_W-1:0] SAT_HI = ENT_W'(rbuv_pkg::OUT_MAX);
  localparam logic signed [ENT_W-1:0] SAT_LO = ENT_W'(rbuv_pkg::OUT_MIN);
  localparam logic signed [ENT_W-1:0] ZERO_E = '0;

  // identity + hat + signed quotient, saturated to 16 bits
  function automatic logic [OUT_W-1:0] ent_calc(input logic signed [ENT_W-1:0] hat,
                                                input rbuv_pkg::quo_t q,
                                                input logic neg,
                                                input logic diag);
    logic signed [ENT_W-1:0] qs;
    logic signed [ENT_W-1:0] e;
    qs = $signed(ENT_W'(q));
    e  = neg ? hat - qs : hat + qs;
    if (diag) begin
      e = e + ONE_E;
    end
    if (e > SAT_HI) begin
      return SAT_HI[OUT_W-1:0];
    end else if (e < SAT_LO) begin
      return SAT_LO[OUT_W-1:0];
    end
    return e[OUT_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic [rbuv_pkg::CFG_W-1:0] min_r;
  logic [NST-1:0]             v_r;
  logic                       out_valid_r, out_valid_nxt;
  logic                       skid_valid_r, skid_valid_nxt;
  logic                       adv, push, pop;
  logic                       ld_main, ld_skid, mv_skid;

  // Whole pipeline moves together; the output buffer always has room for it
  assign adv       = ~skid_valid_r;
  assign in_tready = adv;
  assign push      = adv & v_r[NST-1];
  assign pop       = out_valid_r & out_tready;

  // --------------------------------------------------------------------------
  // Stage 0: input products
  // --------------------------------------------------------------------------
  logic signed [IN_W-1:0]   a_x, a_y, a_z, b_x, b_y, b_z;
  logic signed [PROD_W-1:0] cr_nxt [6];
  logic signed [PROD_W-1:0] dp_nxt [3];
  logic signed [PROD_W-1:0] cr_r   [6];
  logic signed [PROD_W-1:0] dp_r   [3];

  assign a_x = $signed(in_tdata[15:0]);
  assign a_y = $signed(in_tdata[31:16]);
  assign a_z = $signed(in_tdata[47:32]);
  assign b_x = $signed(in_tdata[63:48]);
  assign b_y = $signed(in_tdata[79:64]);
  assign b_z = $signed(in_tdata[95:80]);

  always_comb begin
    cr_nxt[0] = PROD_W'(a_y) * PROD_W'(b_z);
    cr_nxt[1] = PROD_W'(a_z) * PROD_W'(b_y);
    cr_nxt[2] = PROD_W'(a_z) * PROD_W'(b_x);
    cr_nxt[3] = PROD_W'(a_x) * PROD_W'(b_z);
    cr_nxt[4] = PROD_W'(a_x) * PROD_W'(b_y);
    cr_nxt[5] = PROD_W'(a_y) * PROD_W'(b_x);
    dp_nxt[0] = PROD_W'(a_x) * PROD_W'(b_x);
    dp_nxt[1] = PROD_W'(a_y) * PROD_W'(b_y);
    dp_nxt[2] = PROD_W'(a_z) * PROD_W'(b_z);
  end

  // --------------------------------------------------------------------------
  // Stage 1: cross differences, dot partial sum
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] df_nxt [3];
  logic signed [DIFF_W-1:0] df_r   [3];
  logic signed [DIFF_W-1:0] dsum_nxt, dsum_r;
  logic signed [PROD_W-1:0] dp2_r;

  always_comb begin
    df_nxt[0] = DIFF_W'(cr_r[0]) - DIFF_W'(cr_r[1]);
    df_nxt[1] = DIFF_W'(cr_r[2]) - DIFF_W'(cr_r[3]);
    df_nxt[2] = DIFF_W'(cr_r[4]) - DIFF_W'(cr_r[5]);
    dsum_nxt  = DIFF_W'(dp_r[0]) + DIFF_W'(dp_r[1]);
  end

  // --------------------------------------------------------------------------
  // Stage 2: round c to Q.14 (ties away from zero), denominator 1 + a.b
  // --------------------------------------------------------------------------
  logic signed [RND_W-1:0] rnd [3];
  logic signed [C_W-1:0]   c_nxt [3];
  logic signed [C_W-1:0]   c2_r  [3];
  logic signed [DEN_W-1:0] den_nxt, den_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]   = RND_W'(df_r[i]) + (df_r[i][DIFF_W-1] ? RND_W'(rbuv_pkg::RND_NEG)
                                                      : RND_W'(rbuv_pkg::RND_POS));
      c_nxt[i] = rnd[i][FRAC_W+C_W-1:FRAC_W];
    end
    den_nxt = DEN_W'(dsum_r) + DEN_W'(dp2_r) + DEN_W'(rbuv_pkg::ONE_Q28);
  end

  // --------------------------------------------------------------------------
  // Stage 3: c products, degenerate check
  // --------------------------------------------------------------------------
  logic signed [SQ_W-1:0]  sq_nxt [6];
  logic signed [SQ_W-1:0]  sq_r   [6];
  logic signed [C_W-1:0]   c3_r   [3];
  logic signed [DEN_W-1:0] thr;
  logic                    degen_nxt, degen3_r;
  rbuv_pkg::div_t          d3_r;

  always_comb begin
    sq_nxt[0] = SQ_W'(c2_r[0]) * SQ_W'(c2_r[0]);
    sq_nxt[1] = SQ_W'(c2_r[1]) * SQ_W'(c2_r[1]);
    sq_nxt[2] = SQ_W'(c2_r[2]) * SQ_W'(c2_r[2]);
    sq_nxt[3] = SQ_W'(c2_r[0]) * SQ_W'(c2_r[1]);
    sq_nxt[4] = SQ_W'(c2_r[2]) * SQ_W'(c2_r[0]);
    sq_nxt[5] = SQ_W'(c2_r[1]) * SQ_W'(c2_r[2]);
    thr       = $signed(DEN_W'({min_r, {FRAC_W{1'b0}}}));
    degen_nxt = den_r <= thr;
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitudes and signs of the six [c]x^2 entries
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] mag_nxt [LANES];
  logic [MAG_W-1:0] mag_r   [LANES];
  rbuv_pkg::side_t  side4_nxt, side4_r;
  rbuv_pkg::div_t   d4_r;

  always_comb begin
    // diagonal entries are minus a sum of squares
    mag_nxt[LN_S00] = MAG_W'(sq_r[1] + sq_r[2]);
    mag_nxt[LN_S11] = MAG_W'(sq_r[0] + sq_r[2]);
    mag_nxt[LN_S22] = MAG_W'(sq_r[0] + sq_r[1]);
    mag_nxt[LN_S01] = MAG_W'(sq_r[3][SQ_W-1] ? -sq_r[3] : sq_r[3]);
    mag_nxt[LN_S02] = MAG_W'(sq_r[4][SQ_W-1] ? -sq_r[4] : sq_r[4]);
    mag_nxt[LN_S12] = MAG_W'(sq_r[5][SQ_W-1] ? -sq_r[5] : sq_r[5]);

    side4_nxt.c0          = c3_r[0];
    side4_nxt.c1          = c3_r[1];
    side4_nxt.c2          = c3_r[2];
    side4_nxt.neg         = '0;
    side4_nxt.neg[LN_S00] = 1'b1;
    side4_nxt.neg[LN_S11] = 1'b1;
    side4_nxt.neg[LN_S22] = 1'b1;
    side4_nxt.neg[LN_S01] = sq_r[3][SQ_W-1];
    side4_nxt.neg[LN_S02] = sq_r[4][SQ_W-1];
    side4_nxt.neg[LN_S12] = sq_r[5][SQ_W-1];
    side4_nxt.degen       = degen3_r;
  end

  // --------------------------------------------------------------------------
  // Stage 5: rounded numerators |h| * 2^14 + den / 2
  // --------------------------------------------------------------------------
  rbuv_pkg::num_t  num_nxt [LANES];
  rbuv_pkg::num_t  num_r   [LANES];
  rbuv_pkg::side_t side5_r;
  rbuv_pkg::div_t  d5_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num_nxt[l] = (NUM_W'(mag_r[l]) << FRAC_W) + NUM_W'(d4_r >> 1);
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers of the front stages
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      cr_r     <= cr_nxt;
      dp_r     <= dp_nxt;
      df_r     <= df_nxt;
      dsum_r   <= dsum_nxt;
      dp2_r    <= dp_r[2];
      c2_r     <= c_nxt;
      den_r    <= den_nxt;
      sq_r     <= sq_nxt;
      c3_r     <= c2_r;
      degen3_r <= degen_nxt;
      d3_r     <= den_r[DIV_W-1:0];
      mag_r    <= mag_nxt;
      side4_r  <= side4_nxt;
      d4_r     <= d3_r;
      num_r    <= num_nxt;
      side5_r  <= side4_r;
      d5_r     <= d4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Divider and its sideband
  // --------------------------------------------------------------------------
  rbuv_pkg::quo_t  quo [LANES];
  rbuv_pkg::side_t sb_r [DS];

  rbuv_div u_div (
    .clk   (clk),
    .en    (adv),
    .num_i (num_r),
    .den_i (d5_r),
    .quo_o (quo)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= side5_r;
      for (int s = 1; s < DS; s++) begin
        sb_r[s] <= sb_r[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final entries: identity + hat + quotient, saturated
  // --------------------------------------------------------------------------
  rbuv_pkg::side_t         sd;
  logic signed [ENT_W-1:0] c0e, c1e, c2e;
  rbuv_pkg::res_t          res;

  assign sd  = sb_r[DS-1];
  assign c0e = ENT_W'(sd.c0);
  assign c1e = ENT_W'(sd.c1);
  assign c2e = ENT_W'(sd.c2);

  always_comb begin
    res.degen  = sd.degen;
    res.ent[0] = ent_calc(ZERO_E, quo[LN_S00], sd.neg[LN_S00], 1'b1);
    res.ent[1] = ent_calc(-c2e,   quo[LN_S01], sd.neg[LN_S01], 1'b0);
    res.ent[2] = ent_calc(c1e,    quo[LN_S02], sd.neg[LN_S02], 1'b0);
    res.ent[3] = ent_calc(c2e,    quo[LN_S01], sd.neg[LN_S01], 1'b0);
    res.ent[4] = ent_calc(ZERO_E, quo[LN_S11], sd.neg[LN_S11], 1'b1);
    res.ent[5] = ent_calc(-c0e,   quo[LN_S12], sd.neg[LN_S12], 1'b0);
    res.ent[6] = ent_calc(-c1e,   quo[LN_S02], sd.neg[LN_S02], 1'b0);
    res.ent[7] = ent_calc(c0e,    quo[LN_S12], sd.neg[LN_S12], 1'b0);
    res.ent[8] = ent_calc(ZERO_E, quo[LN_S22], sd.neg[LN_S22], 1'b1);
    // degenerate pair: matrix reads as zero
    if (sd.degen) begin
      res.ent = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer: main register plus one skid entry
  // --------------------------------------------------------------------------
  rbuv_pkg::res_t out_res_r, skid_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    ld_main        = 1'b0;
    ld_skid        = 1'b0;
    mv_skid        = 1'b0;
    if (skid_valid_r) begin
      if (pop) begin
        mv_skid        = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        ld_skid        = 1'b1;
        skid_valid_nxt = 1'b1;
      end else begin
        ld_main       = 1'b1;
        out_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_main) begin
      out_res_r <= res;
    end else if (mv_skid) begin
      out_res_r <= skid_res_r;
    end
    if (ld_skid) begin
      skid_res_r <= res;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r        <= rbuv_pkg::CFG_W'(rbuv_pkg::CFG_RST);
      v_r          <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_r <= cfg_wdata;
      end
      if (adv) begin
        v_r <= {v_r[NST-2:0], in_tvalid};
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.ent;
  assign out_tuser  = out_res_r.degen;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // skid entry is only ever filled behind a full main register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty main register");

  // a degenerate result carries an all-zero matrix
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("degenerate result with nonzero matrix");

  // a stalled pipeline keeps its valid bits
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipeline valid bits moved during stall");

  // a result arriving at a blocked output lands in the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NST-1] && adv && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("result dropped at blocked output");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for rotation_between_unit_vectors
// Streams vector pairs through the block with random sender gaps and receiver
// stalls, predicts each rotation matrix and degenerate flag in Q2.14, and
// compares every result item field by field. The minimum-denominator
// register is stepped through several settings between drained phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 200000;

  localparam int IN_W   = rbuv_pkg::IN_W;
  localparam int OUT_W  = rbuv_pkg::OUT_W;
  localparam int CFG_W  = rbuv_pkg::CFG_W;
  localparam int FRAC_W = rbuv_pkg::FRAC_W;
  localparam int NENT   = rbuv_pkg::NENT;

  // One component triple and one input item, x / a in the low bits
  typedef struct packed {
    logic signed [IN_W-1:0] z;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] x;
  } vec3_t;

  typedef struct packed {
    vec3_t b;
    vec3_t a;
  } pair_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [15:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;        // a_x, a_y, a_z, b_x, b_y, b_z
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;            // r00, r01, r02, r10, r11, r12, r20, r21, r22
  logic         out_tuser;            // degenerate

  pair_t            pending_pairs[$];
  rbuv_pkg::res_t   expected_rot[$];
  logic [CFG_W-1:0] min_den_cfg = CFG_W'(rbuv_pkg::CFG_RST);
  logic         in_acc = 1'b0;
  int           errors = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  int           stall_mode = 0;

  rotation_between_unit_vectors u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Q.28 to Q.14, ties away from zero
  function automatic longint round_q14(longint v);
    longint m;
    m = ((v < 0) ? -v : v) + (1 << (FRAC_W - 1));
    m = m >>> FRAC_W;
    return (v < 0) ? -m : m;
  endfunction

  // Expected matrix and flag for one pair under a given minimum denominator
  function automatic rbuv_pkg::res_t predict_rotation(pair_t p, logic [CFG_W-1:0] min_den);
    longint a[3], b[3], c[3], hat[9], sq[9];
    longint dot, den, mag, q, e;
    rbuv_pkg::res_t r;
    a[0] = $signed(p.a.x); a[1] = $signed(p.a.y); a[2] = $signed(p.a.z);
    b[0] = $signed(p.b.x); b[1] = $signed(p.b.y); b[2] = $signed(p.b.z);
    c[0] = round_q14(a[1] * b[2] - a[2] * b[1]);
    c[1] = round_q14(a[2] * b[0] - a[0] * b[2]);
    c[2] = round_q14(a[0] * b[1] - a[1] * b[0]);
    dot = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    den = (longint'(1) << (2 * FRAC_W)) + dot;
    r = '0;
    if (den <= (longint'(min_den) << FRAC_W)) begin
      r.degen = 1'b1;
      return r;
    end
    hat[0] = 0;     hat[1] = -c[2]; hat[2] = c[1];
    hat[3] = c[2];  hat[4] = 0;     hat[5] = -c[0];
    hat[6] = -c[1]; hat[7] = c[0];  hat[8] = 0;
    sq[0] = -c[1] * c[1] - c[2] * c[2];
    sq[1] = c[0] * c[1];
    sq[2] = c[2] * c[0];
    sq[3] = sq[1];
    sq[4] = -c[0] * c[0] - c[2] * c[2];
    sq[5] = c[1] * c[2];
    sq[6] = sq[2];
    sq[7] = sq[5];
    sq[8] = -c[0] * c[0] - c[1] * c[1];
    for (int i = 0; i < NENT; i++) begin
      // quotient rounded on the magnitude, sign restored afterwards
      mag = (sq[i] < 0) ? -sq[i] : sq[i];
      q = ((mag << FRAC_W) + den / 2) / den;
      if (sq[i] < 0) q = -q;
      e = hat[i] + q + ((i % 4 == 0) ? rbuv_pkg::ONE_Q14 : 0);
      if (e > rbuv_pkg::OUT_MAX) e = rbuv_pkg::OUT_MAX;
      if (e < rbuv_pkg::OUT_MIN) e = rbuv_pkg::OUT_MIN;
      r.ent[i] = e[OUT_W-1:0];
    end
    return r;
  endfunction

  // Random unit vector in Q2.14
  function automatic vec3_t rand_unit();
    real x, y, z, n;
    vec3_t v;
    do begin
      x = $urandom_range(0, 32768) - 16384.0;
      y = $urandom_range(0, 32768) - 16384.0;
      z = $urandom_range(0, 32768) - 16384.0;
      n = $sqrt(x * x + y * y + z * z);
    end while (n < 1.0);
    v.x = IN_W'(int'(x * 16384.0 / n));
    v.y = IN_W'(int'(y * 16384.0 / n));
    v.z = IN_W'(int'(z * 16384.0 / n));
    return v;
  endfunction

  function automatic int jitter(int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  task automatic add_pair(int ax, int ay, int az, int bx, int by, int bz);
    pair_t p;
    p.a.x = IN_W'(ax); p.a.y = IN_W'(ay); p.a.z = IN_W'(az);
    p.b.x = IN_W'(bx); p.b.y = IN_W'(by); p.b.z = IN_W'(bz);
    pending_pairs.push_back(p);
  endtask

  // Mostly unit pairs, with near-opposite pairs around the threshold,
  // near-equal pairs and raw 16-bit noise
  task automatic add_random(int n);
    pair_t p;
    int kind, amp;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      p.a = rand_unit();
      if (kind < 55) begin
        p.b = rand_unit();
      end else if (kind < 75) begin
        case ($urandom_range(0, 3))
          0:       amp = 4;
          1:       amp = 64;
          2:       amp = 1024;
          default: amp = 6000;
        endcase
        p.b.x = IN_W'(-p.a.x + jitter(amp));
        p.b.y = IN_W'(-p.a.y + jitter(amp));
        p.b.z = IN_W'(-p.a.z + jitter(amp));
      end else if (kind < 85) begin
        amp = $urandom_range(0, 16);
        p.b.x = IN_W'(p.a.x + jitter(amp));
        p.b.y = IN_W'(p.a.y + jitter(amp));
        p.b.z = IN_W'(p.a.z + jitter(amp));
      end else begin
        p = pair_t'({$urandom, $urandom, $urandom});
      end
      pending_pairs.push_back(p);
    end
  endtask

  // Wait until every item is sent and every result has come back
  task automatic drain();
    while (pending_pairs.size() != 0 || in_tvalid || expected_rot.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_min_den(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    min_den_cfg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sequence of phases
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: axes, extremes, threshold and rounding ties
    add_pair(16384, 0, 0, 16384, 0, 0);
    add_pair(16384, 0, 0, 0, 16384, 0);
    add_pair(0, 16384, 0, 0, 0, 16384);
    add_pair(16384, 0, 0, -16384, 0, 0);
    add_pair(0, 0, 0, 0, 0, 0);
    add_pair(16384, 16384, 16384, 16384, 16384, 16384);
    add_pair(-16384, -16384, -16384, 16384, 16384, 16384);
    add_pair(16384, 0, 0, -16383, 0, 0);      // denominator equals threshold
    add_pair(16384, 0, 0, -16382, 1, 0);      // quotient tie
    add_pair(0, 1, 0, 0, 0, 8192);            // cross tie, positive
    add_pair(0, 8192, 0, 0, 0, -1);           // cross tie, negative
    add_pair(32767, 0, 0, 0, 32767, 0);       // entries saturate
    add_pair(32767, -32768, 32767, -32768, 32767, -32768);
    add_pair(-32768, -32768, -32768, -32768, -32768, -32768);
    add_pair(0, 32767, -32768, 32767, 0, 32767);
    add_pair(11585, 11585, 0, 0, 11585, 11585);
    add_random(130);
    drain();

    // zero threshold: exact zero denominator still degenerate
    set_min_den(16'd0);
    add_pair(16384, 0, 0, -16384, 0, 0);
    add_pair(16384, 0, 0, -16383, 0, 5);
    add_pair(0, 0, -16384, 0, 0, 16384);
    add_random(140);
    drain();

    set_min_den(16'd32768);
    add_random(60);
    drain();

    set_min_den(16'd16384);
    add_random(120);
    drain();

    set_min_den(16'($urandom_range(0, 2000)));
    add_random(140);
    drain();

    set_min_den(16'($urandom_range(0, 32768)));
    add_random(90);
    drain();

    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Sender: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (gap_left > 0 || pending_pairs.size() == 0) begin
        if (gap_left > 0) gap_left = gap_left - 1;
        in_tvalid <= 1'b0;
      end else begin
        in_tdata <= pending_pairs.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: stall pattern whose mode is redrawn when its countdown runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      stall_left = $urandom_range(32, 256);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= ($urandom_range(0, 3) != 0);
      3:       out_tready <= ((cycle_count % 8) < 3);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Monitor: predict on input accept, check on result accept
  always @(posedge clk) begin
    rbuv_pkg::res_t want;
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("DONE: errors detected");
      $finish;
    end else begin
      in_acc <= rst_n && in_tvalid && in_tready;
      if (rst_n && in_tvalid && in_tready)
        expected_rot.push_back(predict_rotation(pair_t'(in_tdata), min_den_cfg));
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_rot.size() == 0) begin
          $display("%0t: result item with none expected, tdata %h tuser %b",
                   $time, out_tdata, out_tuser);
          errors = errors + 1;
        end else begin
          want = expected_rot.pop_front();
          for (int i = 0; i < NENT; i++) begin
            if (out_tdata[OUT_W*i +: OUT_W] !== want.ent[i]) begin
              $display("%0t: r%0d%0d expected %0d got %0d", $time, i / 3, i % 3,
                       $signed(want.ent[i]), $signed(out_tdata[OUT_W*i +: OUT_W]));
              errors = errors + 1;
            end
          end
          if (out_tuser !== want.degen) begin
            $display("%0t: degenerate expected %0b got %0b", $time, want.degen, out_tuser);
            errors = errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ files.f @@
rtl/core/rbuv_pkg.sv
rtl/core/rbuv_div.sv
rtl/core/rotation_between_unit_vectors.sv
bench/tb_top.sv
